FILE: src/wcpd_pkg.sv
// ----------------------------------------------------------------------------
// wcpd_pkg
// Types, constants and bitwise CRC16 / PN9 helpers shared by the whitened,
// CRC16-checked packet deframer.
// ----------------------------------------------------------------------------
package wcpd_pkg;

  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [8:0]  PN9_SEED = 9'h1FF;
  localparam logic [8:0]  CRC_BYTES = 9'd2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DEWHITEN_ENABLE  = 2'd0,
    CFG_CRC_ENABLE       = 2'd1,
    CFG_DROP_LENGTH_BYTE = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic dewhiten_enable;
    logic crc_enable;
    logic drop_length_byte;
  } cfg_t;

  typedef struct packed {
    logic data_bit;
    logic sync_flag;
  } sample_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       frame_end;
    logic       crc_ok;
  } result_t;

  // CRC16, polynomial 0x8005, MSB first, over one byte.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    logic [7:0]  d;
    logic        top;
    c = crc;
    d = data;
    for (int k = 0; k < 8; k++) begin
      top = c[15] ^ d[7];
      c = {c[14:0], 1'b0};
      if (top) begin
        c = c ^ CRC_POLY;
      end
      d = {d[6:0], 1'b0};
    end
    return c;
  endfunction

  // PN9 (x^9 + x^5 + 1) advanced by eight steps.
  function automatic logic [8:0] pn9_advance_byte(logic [8:0] lfsr);
    logic [8:0] s;
    logic       fb;
    s = lfsr;
    for (int k = 0; k < 8; k++) begin
      fb = s[0] ^ s[5];
      s = {fb, s[8:1]};
    end
    return s;
  endfunction

endpackage

FILE: src/wcpd_core.sv
// ----------------------------------------------------------------------------
// wcpd_core
// Frame state and per-bit datapath: bit packing, dewhitening, length decode,
// CRC16 accumulation and the frame-end check. One sample per step.
// ----------------------------------------------------------------------------
module wcpd_core (
  input  logic              clk,
  input  logic              rst,
  input  wcpd_pkg::cfg_t    cfg,
  input  wcpd_pkg::sample_t item,
  input  logic              step,
  output logic              has_result,
  output wcpd_pkg::result_t res
);
  import wcpd_pkg::*;

  logic        in_frame;
  logic [2:0]  bit_count;
  logic [8:0]  byte_count;
  logic [7:0]  shift_byte;
  logic [8:0]  frame_length;
  logic [15:0] crc_register;
  logic [7:0]  received_crc_high;
  logic [8:0]  whitening_lfsr;

  logic        in_frame_next;
  logic [2:0]  bit_count_next;
  logic [8:0]  byte_count_next;
  logic [7:0]  shift_byte_next;
  logic [8:0]  frame_length_next;
  logic [15:0] crc_register_next;
  logic [7:0]  received_crc_high_next;
  logic [8:0]  whitening_lfsr_next;

  logic        active;
  logic        starting;
  logic [2:0]  bc_cur;
  logic [8:0]  idx;
  logic [7:0]  shift_cur;
  logic [8:0]  fl_cur;
  logic [15:0] crc_cur;
  logic [7:0]  crch_cur;
  logic [8:0]  lfsr_cur;
  logic        byte_done;
  logic [7:0]  wb;
  logic [8:0]  crc_extra;
  logic [8:0]  data_bytes;
  logic        last;
  logic        payload_byte;
  logic        crc_high_byte;
  logic        crc_match;
  logic        emit;
  logic        ok;

  always_comb begin
    active   = in_frame || item.sync_flag;
    starting = !in_frame;

    // A frame that starts on this bit sees the freshly cleared state.
    bc_cur    = starting ? 3'd0 : bit_count;
    idx       = starting ? 9'd0 : byte_count;
    shift_cur = starting ? 8'd0 : shift_byte;
    fl_cur    = starting ? 9'd0 : frame_length;
    crc_cur   = starting ? CRC_SEED : crc_register;
    crch_cur  = starting ? 8'd0 : received_crc_high;
    lfsr_cur  = starting ? PN9_SEED : whitening_lfsr;

    shift_byte_next = {shift_cur[6:0], item.data_bit};
    bit_count_next  = bc_cur + 3'd1;
    byte_done       = active && (bit_count_next == 3'd0);

    wb = shift_byte_next ^ (cfg.dewhiten_enable ? lfsr_cur[7:0] : 8'd0);
    crc_extra = cfg.crc_enable ? CRC_BYTES : 9'd0;

    frame_length_next = (idx == 9'd0) ? ({1'b0, wb} + 9'd1 + crc_extra) : fl_cur;
    // Only meaningful when the frame holds at least two bytes.
    data_bytes = frame_length_next - crc_extra;
    last = ({1'b0, idx} + 10'd1) >= {1'b0, frame_length_next};

    payload_byte  = (idx < data_bytes) || (frame_length_next < 9'd2);
    crc_high_byte = !payload_byte && (idx == data_bytes);
    crc_match     = ({crch_cur, wb} == crc_cur);

    emit = payload_byte && !((idx == 9'd0) && cfg.drop_length_byte);
    ok   = last && (cfg.crc_enable ? (!payload_byte && !crc_high_byte && crc_match)
                                   : 1'b1);

    has_result     = byte_done && (emit || last);
    res.data_byte  = emit ? wb : 8'd0;
    res.data_valid = emit;
    res.frame_end  = last;
    res.crc_ok     = ok;

    in_frame_next          = byte_done ? !last : 1'b1;
    byte_count_next        = byte_done ? (idx + 9'd1) : idx;
    whitening_lfsr_next    = byte_done ? pn9_advance_byte(lfsr_cur) : lfsr_cur;
    crc_register_next      = (byte_done && payload_byte) ? crc16_byte(crc_cur, wb) : crc_cur;
    received_crc_high_next = (byte_done && crc_high_byte) ? wb : crch_cur;
    if (!byte_done) begin
      frame_length_next = fl_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame          <= 1'b0;
      bit_count         <= 3'd0;
      byte_count        <= 9'd0;
      shift_byte        <= 8'd0;
      frame_length      <= 9'd0;
      crc_register      <= CRC_SEED;
      received_crc_high <= 8'd0;
      whitening_lfsr    <= PN9_SEED;
    end else if (step && active) begin
      in_frame          <= in_frame_next;
      bit_count         <= bit_count_next;
      byte_count        <= byte_count_next;
      shift_byte        <= shift_byte_next;
      frame_length      <= frame_length_next;
      crc_register      <= crc_register_next;
      received_crc_high <= received_crc_high_next;
      whitening_lfsr    <= whitening_lfsr_next;
    end
  end

endmodule

FILE: src/whitened_crc16_packet_deframer.sv
// ----------------------------------------------------------------------------
// whitened_crc16_packet_deframer
// Packs received bits into bytes, removes PN9 whitening, decodes the length
// header, emits header and payload bytes and checks the trailing CRC16.
//
//   channel   direction  handshake              payload
//   sample    in         sample_valid/stall     wcpd_pkg::sample_t
//   result    out        result_valid/stall     wcpd_pkg::result_t
//   cfg       in         cfg_valid/ready        cfg_index, cfg_data
//
// One sample per cycle while no result is held by a stall: a sample register
// feeds the frame datapath, whose byte result lands in the result register in
// the same cycle as the sample is taken from the sample register.
// Reset is synchronous; it clears the frame state and restores register
// defaults. A stalled result holds only samples that would produce a result;
// bits inside a byte keep flowing.
// ----------------------------------------------------------------------------
module whitened_crc16_packet_deframer (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  wcpd_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_stall,
  output wcpd_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic              cfg_data
);
  import wcpd_pkg::*;

  cfg_t    cfg;
  logic    s1_valid;
  sample_t s1_item;
  logic    has_result;
  result_t core_res;
  logic    out_free;
  logic    advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dewhiten_enable  <= 1'b1;
      cfg.crc_enable       <= 1'b1;
      cfg.drop_length_byte <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEWHITEN_ENABLE:  cfg.dewhiten_enable  <= cfg_data;
        CFG_CRC_ENABLE:       cfg.crc_enable       <= cfg_data;
        CFG_DROP_LENGTH_BYTE: cfg.drop_length_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free     = !result_valid || !result_stall;
  assign advance      = s1_valid && (!has_result || out_free);
  assign sample_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1_item <= sample;
    end
  end

  wcpd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (s1_item),
    .step       (advance),
    .has_result (has_result),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && has_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      result <= core_res;
    end
  end

  // A CRC verdict only ever comes with the end of a frame.
  a_ok_needs_end: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.crc_ok || result.frame_end))
    else $error("crc_ok set without frame_end");

  // A result without a byte must be the frame end, with a zero byte.
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.data_valid) |-> (result.frame_end && result.data_byte == 8'd0))
    else $error("empty result that does not end a frame");

  // A held sample stays in the sample register unchanged.
  a_sample_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_item)))
    else $error("held sample lost or changed");

  // A result is never overwritten while the consumer stalls it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !(advance && has_result))
    else $error("result overwritten under stall");

endmodule

FILE: tb/sv/whitened_crc16_packet_deframer_tb.sv
// ----------------------------------------------------------------------------
// whitened_crc16_packet_deframer_tb
// Self-checking bench for the deframer. A short table of hand-built frames
// covers the corner cases, then random frames run under every
// register setting. Each bit transfer is fed to a bit-level model of the
// deframer, and each result transfer is compared field by field with the
// oldest predicted result. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module whitened_crc16_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wcpd_pkg::*;

  typedef enum logic [2:0] {
    ROW_CFG,
    ROW_IDLE,
    ROW_START,
    ROW_DATA,
    ROW_CRC
  } row_kind_t;

  // One line of the hand-built plan. For CRC lines, value is a mask that
  // is xored into the low CRC byte.
  typedef struct packed {
    row_kind_t  kind;
    logic       sync;
    logic [7:0] value;
    cfg_index_t reg_sel;
    logic       reg_val;
    logic       typed;
    logic       has_want;
    result_t    want;
  } row_t;

  // One bit on the air, with an optional hand-typed expectation.
  typedef struct packed {
    sample_t s;
    logic    typed;
    logic    has_want;
    result_t want;
  } air_bit_t;

  localparam result_t NO_RESULT = '0;
  localparam int HOLD_CYCLES = 400;

  localparam row_t DIRECTED [0:24] = '{
    '{ROW_IDLE,  0, 8'h5A, CFG_DEWHITEN_ENABLE,  0, 1, 0, NO_RESULT},
    '{ROW_START, 1, 8'h02, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'h02, 1, 0, 0}},
    '{ROW_DATA,  0, 8'h00, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'h00, 1, 0, 0}},
    '{ROW_DATA,  0, 8'hFF, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'hFF, 1, 0, 0}},
    '{ROW_CRC,   0, 8'h00, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'h00, 0, 1, 1}},
    '{ROW_START, 1, 8'h01, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'h01, 1, 0, 0}},
    '{ROW_DATA,  1, 8'h80, CFG_DEWHITEN_ENABLE,  0, 0, 0, NO_RESULT},
    '{ROW_CRC,   0, 8'h01, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'h00, 0, 1, 0}},
    '{ROW_CFG,   0, 8'h00, CFG_DROP_LENGTH_BYTE, 1, 0, 0, NO_RESULT},
    '{ROW_START, 1, 8'h01, CFG_DEWHITEN_ENABLE,  0, 1, 0, NO_RESULT},
    '{ROW_DATA,  0, 8'h3C, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'h3C, 1, 0, 0}},
    '{ROW_CRC,   0, 8'h00, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'h00, 0, 1, 1}},
    '{ROW_CFG,   0, 8'h00, CFG_CRC_ENABLE,       0, 0, 0, NO_RESULT},
    '{ROW_START, 1, 8'h00, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'h00, 0, 1, 1}},
    '{ROW_CFG,   0, 8'h00, CFG_DROP_LENGTH_BYTE, 0, 0, 0, NO_RESULT},
    '{ROW_START, 1, 8'h00, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'h00, 1, 1, 1}},
    '{ROW_START, 1, 8'h01, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'h01, 1, 0, 0}},
    '{ROW_DATA,  0, 8'h55, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'h55, 1, 1, 1}},
    '{ROW_CFG,   0, 8'h00, CFG_DEWHITEN_ENABLE,  0, 0, 0, NO_RESULT},
    '{ROW_START, 1, 8'h01, CFG_DEWHITEN_ENABLE,  0, 0, 0, NO_RESULT},
    '{ROW_DATA,  0, 8'hAA, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'hAA, 1, 1, 1}},
    '{ROW_CFG,   0, 8'h00, CFG_CRC_ENABLE,       1, 0, 0, NO_RESULT},
    '{ROW_START, 1, 8'h00, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'h00, 1, 0, 0}},
    '{ROW_CRC,   0, 8'h80, CFG_DEWHITEN_ENABLE,  0, 1, 1, '{8'h00, 0, 1, 0}},
    '{ROW_CFG,   0, 8'h00, CFG_DEWHITEN_ENABLE,  1, 0, 0, NO_RESULT}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       sample_valid = 1'b0;
  logic       sample_stall;
  sample_t    sample = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic       cfg_data = 1'b0;

  whitened_crc16_packet_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Register copy and receiver state of the bit-level deframer model.
  cfg_t        cfg_m = '{dewhiten_enable: 1'b1, crc_enable: 1'b1, drop_length_byte: 1'b0};
  logic        rx_busy = 1'b0;
  logic [2:0]  rx_bits = '0;
  logic [8:0]  rx_index = '0;
  logic [7:0]  rx_shift = '0;
  logic [8:0]  rx_len = '0;
  logic [15:0] rx_crc = CRC_SEED;
  logic [7:0]  rx_crc_hi = '0;
  logic [8:0]  rx_pn9 = PN9_SEED;

  // Transmit side of the frame builder.
  logic [15:0] tx_crc = CRC_SEED;
  logic [8:0]  tx_pn9 = PN9_SEED;

  air_bit_t air_bits [$];
  result_t  awaited_results [$];
  int       bits_pushed = 0;
  int       mismatches = 0;

  air_bit_t on_wire;
  logic     offering = 1'b0;
  int       send_gap = 0;
  logic     sender_quiet = 1'b0;
  logic     receiver_quiet = 1'b0;
  int       stall_left = 0;
  int       hold_left = 0;
  int       hold_requests = 0;
  int       hold_served = 0;
  result_t  model_out;
  logic     produced;

  function automatic logic [15:0] crc16_update(logic [15:0] acc, logic [7:0] octet);
    logic [15:0] c;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      c = (c[15] ^ octet[i]) ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [8:0] pn9_after_byte(logic [8:0] st);
    logic [8:0] s;
    s = st;
    repeat (8) s = {s[0] ^ s[5], s[8:1]};
    return s;
  endfunction

  // Takes one received bit; returns 1 and the result when the bit causes one.
  function automatic logic deframe_bit(input sample_t s, output result_t r);
    logic [7:0] b;
    logic [8:0] idx;
    logic [9:0] body;
    logic       last;
    logic       keep;
    logic       ok;
    r = '0;
    if (!rx_busy) begin
      if (!s.sync_flag) return 1'b0;
      rx_busy = 1'b1;
      rx_bits = '0;
      rx_index = '0;
      rx_shift = '0;
      rx_len = '0;
      rx_crc = CRC_SEED;
      rx_crc_hi = '0;
      rx_pn9 = PN9_SEED;
    end
    rx_shift = {rx_shift[6:0], s.data_bit};
    rx_bits = rx_bits + 3'd1;
    if (rx_bits != 3'd0) return 1'b0;
    b = rx_shift ^ (cfg_m.dewhiten_enable ? rx_pn9[7:0] : 8'h00);
    rx_pn9 = pn9_after_byte(rx_pn9);
    idx = rx_index;
    rx_index = rx_index + 9'd1;
    if (idx == 9'd0) begin
      rx_len = {1'b0, b} + 9'd1 + (cfg_m.crc_enable ? CRC_BYTES : 9'd0);
    end
    body = {1'b0, rx_len} - (cfg_m.crc_enable ? 10'd2 : 10'd0);
    last = ({1'b0, idx} + 10'd1 >= {1'b0, rx_len});
    keep = 1'b0;
    ok = 1'b0;
    if ({1'b0, idx} < body || rx_len < 9'd2) begin
      rx_crc = crc16_update(rx_crc, b);
      keep = !(idx == 9'd0 && cfg_m.drop_length_byte);
    end else if ({1'b0, idx} == body) begin
      rx_crc_hi = b;
    end else begin
      ok = ({rx_crc_hi, b} == rx_crc);
    end
    if (last) begin
      rx_busy = 1'b0;
      if (!cfg_m.crc_enable) ok = 1'b1;
    end else begin
      ok = 1'b0;
    end
    if (!keep && !last) return 1'b0;
    r.data_byte = keep ? b : 8'h00;
    r.data_valid = keep;
    r.frame_end = last;
    r.crc_ok = ok;
    return 1'b1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 24);
    return $urandom_range(25, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, got);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      check_field("data_byte", want.data_byte, got.data_byte);
      check_field("data_valid", {7'd0, want.data_valid}, {7'd0, got.data_valid});
      check_field("frame_end", {7'd0, want.frame_end}, {7'd0, got.frame_end});
      check_field("crc_ok", {7'd0, want.crc_ok}, {7'd0, got.crc_ok});
    end
  endtask

  // Sender, model and result checker share one process so that a transfer
  // is always predicted before its result can be compared.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      offering = 1'b0;
      send_gap = 0;
    end else begin
      if (result_valid && !result_stall) check_result(result);
      if (sample_valid && !sample_stall) begin
        produced = deframe_bit(on_wire.s, model_out);
        if (on_wire.typed) begin
          if (on_wire.has_want) awaited_results.push_back(on_wire.want);
        end else if (produced) begin
          awaited_results.push_back(model_out);
        end
        offering = 1'b0;
        send_gap = sender_quiet ? 0 : gap_len();
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (air_bits.size() > 0) begin
          on_wire = air_bits.pop_front();
          offering = 1'b1;
        end
      end
      sample_valid <= offering;
      sample <= offering ? on_wire.s : sample_t'(2'($urandom));
    end
  end

  // Receiver back-pressure, including the one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (receiver_quiet || $urandom_range(0, 2) != 0) begin
        result_stall <= 1'b0;
      end else begin
        stall_left = gap_len();
        result_stall <= 1'b1;
      end
    end
  end

  task automatic push_bits(logic [7:0] raw, logic sync_first, logic typed, logic has_want,
                           result_t want);
    air_bit_t ab;
    for (int k = 7; k >= 0; k--) begin
      ab.s.data_bit = raw[k];
      ab.s.sync_flag = (k == 7) ? sync_first : 1'b0;
      ab.typed = typed;
      ab.has_want = has_want && (k == 0);
      ab.want = want;
      air_bits.push_back(ab);
      bits_pushed++;
    end
  endtask

  task automatic push_frame_byte(logic [7:0] plain, logic sync_first, logic typed,
                                 logic has_want, result_t want);
    logic [7:0] raw;
    raw = plain ^ (cfg_m.dewhiten_enable ? tx_pn9[7:0] : 8'h00);
    tx_pn9 = pn9_after_byte(tx_pn9);
    push_bits(raw, sync_first, typed, has_want, want);
  endtask

  // Header and payload bytes also feed the transmit CRC.
  task automatic push_body_byte(logic [7:0] plain, logic sync_first, logic typed,
                                logic has_want, result_t want);
    push_frame_byte(plain, sync_first, typed, has_want, want);
    tx_crc = crc16_update(tx_crc, plain);
  endtask

  task automatic push_crc(logic [15:0] flip, logic typed, logic has_want, result_t want);
    logic [15:0] c;
    c = tx_crc ^ flip;
    push_frame_byte(c[15:8], 1'b0, typed, 1'b0, want);
    push_frame_byte(c[7:0], 1'b0, typed, has_want, want);
  endtask

  task automatic send_random_frame(int len);
    int          cut;
    logic [15:0] flip;
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) begin
      push_bits(8'($urandom), 1'b0, 1'b0, 1'b0, NO_RESULT);
    end
    cut = ($urandom_range(0, 24) == 0) ? $urandom_range(0, len) : -1;
    tx_pn9 = PN9_SEED;
    tx_crc = CRC_SEED;
    push_body_byte(8'(len), 1'b1, 1'b0, 1'b0, NO_RESULT);
    for (int i = 0; i < len; i++) begin
      // An abandoned frame lets the next frame's bits run in as its data.
      if (i == cut) return;
      push_body_byte(pick_byte(), $urandom_range(0, 19) == 0, 1'b0, 1'b0, NO_RESULT);
    end
    if (cfg_m.crc_enable) begin
      flip = ($urandom_range(0, 6) == 0) ? (16'h0001 << $urandom_range(0, 15)) : 16'h0000;
      push_crc(flip, 1'b0, 1'b0, NO_RESULT);
    end
  endtask

  task automatic wait_idle();
    while (air_bits.size() != 0 || offering || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  // Feeds filler bits until the model is out of any frame still open.
  task automatic close_open_frame();
    wait_idle();
    while (rx_busy) begin
      repeat (4) push_bits(8'($urandom), 1'b0, 1'b0, 1'b0, NO_RESULT);
      wait_idle();
    end
  endtask

  task automatic write_reg(cfg_index_t idx, logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DEWHITEN_ENABLE:  cfg_m.dewhiten_enable = val;
      CFG_CRC_ENABLE:       cfg_m.crc_enable = val;
      CFG_DROP_LENGTH_BYTE: cfg_m.drop_length_byte = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  initial begin
    row_t       row;
    int         ph;
    int         phase_mark;
    int         random_mark;
    logic [2:0] combo;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      case (row.kind)
        ROW_CFG: begin
          wait_idle();
          write_reg(row.reg_sel, row.reg_val);
        end
        ROW_IDLE: push_bits(row.value, row.sync, row.typed, row.has_want, row.want);
        ROW_START, ROW_DATA: begin
          if (row.kind == ROW_START) begin
            tx_pn9 = PN9_SEED;
            tx_crc = CRC_SEED;
          end
          push_body_byte(row.value, row.sync, row.typed, row.has_want, row.want);
        end
        ROW_CRC: push_crc({8'h00, row.value}, row.typed, row.has_want, row.want);
        default: ;
      endcase
    end
    close_open_frame();

    random_mark = bits_pushed;
    for (ph = 0; ph < 8 || bits_pushed - random_mark < 700; ph++) begin
      combo = (ph < 8) ? ph[2:0] : 3'($urandom_range(0, 7));
      wait_idle();
      write_reg(CFG_DEWHITEN_ENABLE, combo[0]);
      write_reg(CFG_CRC_ENABLE, combo[1]);
      write_reg(CFG_DROP_LENGTH_BYTE, combo[2]);
      sender_quiet = (ph % 4 == 1) || (ph == 3);
      receiver_quiet = (ph % 4 == 1);
      // Long receiver hold-off while the sender keeps offering bits.
      if (ph == 3) hold_requests++;
      phase_mark = bits_pushed;
      while (bits_pushed - phase_mark < 40) send_random_frame(pick_length());
      close_open_frame();
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
